@@ rtl/osbm_pkg.sv @@
// ----------------------------------------------------------------------------
// osbm_pkg: shared types and constants of the offset search box matcher
// Store sizes, field widths, command and status codes, controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package osbm_pkg;

   localparam int MAX_LIGHTS     = 16;
   localparam int MAX_DETECTIONS = 64;

   localparam int LIGHT_IDX_W = $clog2(MAX_LIGHTS);
   localparam int LIGHT_CNT_W = $clog2(MAX_LIGHTS + 1);
   localparam int DET_IDX_W   = $clog2(MAX_DETECTIONS);
   localparam int DET_CNT_W   = $clog2(MAX_DETECTIONS + 1);

   // signed width for shifted box edges and offsets
   localparam int POS_W   = 18;
   localparam int TOTAL_W = 20;
   localparam int SCORE_W = 16;
   localparam int ID_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [12:0] WIDTH_RESET     = 13'd1920;
   localparam logic [12:0] HEIGHT_RESET    = 13'd1080;
   localparam logic [15:0] THRESHOLD_RESET = 16'd19661;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH     = 2'd0,
      CSR_IMAGE_HEIGHT    = 2'd1,
      CSR_SCORE_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_LOAD_EXPECTED  = 2'd0,
      CMD_LOAD_DETECTION = 2'd1,
      CMD_RUN            = 2'd2,
      CMD_UNUSED         = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_DROPPED  = 2'd1,
      ST_FULL     = 2'd2,
      ST_ORDER    = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LOAD_EXP,
      S_LOAD_DET,
      S_RUN_START,
      S_OUTER_CHK,
      S_OUTER_LATCH,
      S_PAIR_CHK,
      S_PAIR_TEST,
      S_EVAL_CHK,
      S_EVAL_LATCH,
      S_SCAN_CHK,
      S_SCAN_TEST,
      S_SCAN_WAIT,
      S_EVAL_STORE,
      S_EVAL_END,
      S_EMIT_START,
      S_EMIT_NONE,
      S_EMIT_CHK,
      S_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [12:0]     x;
      logic [12:0]     y;
      logic [11:0]     w;
      logic [11:0]     h;
      logic [7:0]      light_type;
   } exp_entry_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [11:0]        x;
      logic [11:0]        y;
      logic [11:0]        w;
      logic [11:0]        h;
      logic [SCORE_W-1:0] score;
   } det_entry_type;

   typedef struct packed {
      logic                   capture;
      logic                   load_exp;
      logic                   load_det;
      logic                   run_init;
      logic                   exp_rd;
      logic [LIGHT_IDX_W-1:0] exp_addr;
      logic                   det_rd;
      logic                   det_use_choice;
      logic [DET_IDX_W-1:0]   det_addr;
      logic                   latch_outer;
      logic                   latch_offset;
      logic                   latch_inner;
      logic                   iou_start;
      logic                   iou_take;
      logic                   eval_store;
      logic                   eval_commit;
      logic                   emit_match;
      logic                   emit_none;
   } dp_cmd_type;

   typedef struct packed {
      logic [LIGHT_CNT_W-1:0] exp_count;
      logic [DET_CNT_W-1:0]   det_count;
      logic                   outer_match;
      logic                   inner_match;
      logic                   iou_done;
      logic                   best_zero;
      logic                   best_valid;
      logic                   last_item;
      logic                   rsp_free;
   } dp_status_type;

endpackage

@@ rtl/osbm_req_if.sv @@
// ----------------------------------------------------------------------------
// osbm_req_if: request channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface osbm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] light_id;
   logic [12:0] box_x;
   logic [12:0] box_y;
   logic [11:0] box_w;
   logic [11:0] box_h;
   logic [15:0] det_score;
   logic [7:0]  light_type;

   modport source (output valid, command, light_id, box_x, box_y, box_w, box_h,
                   det_score, light_type, input ready);
   modport sink (input valid, command, light_id, box_x, box_y, box_w, box_h,
                 det_score, light_type, output ready);
endinterface

@@ rtl/osbm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// osbm_rsp_if: response channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface osbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        match_found;
   logic [15:0] out_id;
   logic [7:0]  out_type;
   logic [11:0] out_x;
   logic [11:0] out_y;
   logic [11:0] out_w;
   logic [11:0] out_h;
   logic        last;

   modport source (output valid, status, match_found, out_id, out_type, out_x,
                   out_y, out_w, out_h, last, input ready);
   modport sink (input valid, status, match_found, out_id, out_type, out_x,
                 out_y, out_w, out_h, last, output ready);
endinterface

@@ rtl/osbm_iou.sv @@
// ----------------------------------------------------------------------------
// osbm_iou: score-weighted intersection over union
// Four arithmetic steps, then a restoring divider with one quotient bit per
// cycle: floor(score * inter / union).
// ----------------------------------------------------------------------------
module osbm_iou (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [osbm_pkg::POS_W-1:0]    ex,
   input  logic signed [osbm_pkg::POS_W-1:0]    ey,
   input  logic [11:0]                          ew,
   input  logic [11:0]                          eh,
   input  logic [11:0]                          dx,
   input  logic [11:0]                          dy,
   input  logic [11:0]                          dw,
   input  logic [11:0]                          dh,
   input  logic [osbm_pkg::SCORE_W-1:0]         score,
   output logic                                 done,
   output logic [osbm_pkg::SCORE_W-1:0]         q
);
   localparam int PW        = osbm_pkg::POS_W;
   localparam int QW        = osbm_pkg::SCORE_W;
   localparam int DIV_FIRST = 4;
   localparam int LAST_STEP = DIV_FIRST + QW - 1;
   localparam int STEP_W    = $clog2(LAST_STEP + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;

   logic signed [PW-1:0] ex_ff, ey_ff;
   logic [11:0]          ew_ff, eh_ff, dx_ff, dy_ff, dw_ff, dh_ff;
   logic [QW-1:0]        score_ff;
   logic signed [PW-1:0] x1_ff, x2_ff, y1_ff, y2_ff;
   logic [11:0]          iw_ff, ih_ff;
   logic [23:0]          ea_ff, da_ff, inter_ff;
   logic [24:0]          uni_ff;
   logic [24:0]          rem_ff;
   logic [QW-1:0]        numlo_ff;
   logic [QW-1:0]        q_ff;

   logic signed [PW-1:0] dxs, dys, exr, eyb, dxr, dyb, xd, yd;
   logic [39:0]          prod;
   logic [25:0]          trial, diff;

   always_comb begin
      dxs   = $signed({{(PW-12){1'b0}}, dx_ff});
      dys   = $signed({{(PW-12){1'b0}}, dy_ff});
      exr   = ex_ff + $signed({{(PW-12){1'b0}}, ew_ff});
      eyb   = ey_ff + $signed({{(PW-12){1'b0}}, eh_ff});
      dxr   = dxs + $signed({{(PW-12){1'b0}}, dw_ff});
      dyb   = dys + $signed({{(PW-12){1'b0}}, dh_ff});
      xd    = x2_ff - x1_ff;
      yd    = y2_ff - y1_ff;
      prod  = score_ff * inter_ff;
      trial = {rem_ff, numlo_ff[QW-1]};
      diff  = trial - {1'b0, uni_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(LAST_STEP)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ex_ff    <= ex;
         ey_ff    <= ey;
         ew_ff    <= ew;
         eh_ff    <= eh;
         dx_ff    <= dx;
         dy_ff    <= dy;
         dw_ff    <= dw;
         dh_ff    <= dh;
         score_ff <= score;
      end else if (busy_ff) begin
         unique case (step_ff)
            STEP_W'(0): begin
               x1_ff <= (ex_ff > dxs) ? ex_ff : dxs;
               y1_ff <= (ey_ff > dys) ? ey_ff : dys;
               x2_ff <= (exr < dxr) ? exr : dxr;
               y2_ff <= (eyb < dyb) ? eyb : dyb;
            end
            STEP_W'(1): begin
               iw_ff <= (xd > 0) ? xd[11:0] : 12'd0;
               ih_ff <= (yd > 0) ? yd[11:0] : 12'd0;
               ea_ff <= ew_ff * eh_ff;
               da_ff <= dw_ff * dh_ff;
            end
            STEP_W'(2): begin
               inter_ff <= iw_ff * ih_ff;
            end
            STEP_W'(3): begin
               uni_ff   <= {1'b0, ea_ff} + {1'b0, da_ff} - {1'b0, inter_ff};
               rem_ff   <= {1'b0, prod[39:QW]};
               numlo_ff <= prod[QW-1:0];
               q_ff     <= '0;
            end
            default: begin
               // one quotient bit per cycle
               if (!diff[25]) begin
                  rem_ff <= diff[24:0];
                  q_ff   <= {q_ff[QW-2:0], 1'b1};
               end else begin
                  rem_ff <= trial[24:0];
                  q_ff   <= {q_ff[QW-2:0], 1'b0};
               end
               numlo_ff <= {numlo_ff[QW-2:0], 1'b0};
            end
         endcase
      end
   end

   assign done = done_ff;
   assign q    = q_ff;
endmodule

@@ rtl/osbm_datapath.sv @@
// ----------------------------------------------------------------------------
// osbm_datapath: stores, geometry and result register
// Holds the expected and detection memories, the frame registers, the offset
// and evaluation registers, the choice banks and the response register.
// ----------------------------------------------------------------------------
module osbm_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  osbm_pkg::dp_cmd_type                  cmd,
   output osbm_pkg::dp_status_type               stat,
   input  logic [15:0]                           req_light_id,
   input  logic [12:0]                           req_box_x,
   input  logic [12:0]                           req_box_y,
   input  logic [11:0]                           req_box_w,
   input  logic [11:0]                           req_box_h,
   input  logic [15:0]                           req_det_score,
   input  logic [7:0]                            req_light_type,
   input  logic                                  csr_wr_en,
   input  logic [osbm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [osbm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_match_found,
   output logic [15:0]                           rsp_out_id,
   output logic [7:0]                            rsp_out_type,
   output logic [11:0]                           rsp_out_x,
   output logic [11:0]                           rsp_out_y,
   output logic [11:0]                           rsp_out_w,
   output logic [11:0]                           rsp_out_h,
   output logic                                  rsp_last
);
   localparam int NL = osbm_pkg::MAX_LIGHTS;
   localparam int ND = osbm_pkg::MAX_DETECTIONS;
   localparam int LI = osbm_pkg::LIGHT_IDX_W;
   localparam int LC = osbm_pkg::LIGHT_CNT_W;
   localparam int DI = osbm_pkg::DET_IDX_W;
   localparam int DC = osbm_pkg::DET_CNT_W;
   localparam int PW = osbm_pkg::POS_W;
   localparam int TW = osbm_pkg::TOTAL_W;
   localparam int QW = osbm_pkg::SCORE_W;

   // configuration
   logic [12:0] width_ff, height_ff;
   logic [15:0] threshold_ff;

   // captured request payload
   logic [15:0] cap_id_ff;
   logic [12:0] cap_x_ff, cap_y_ff;
   logic [11:0] cap_w_ff, cap_h_ff;
   logic [15:0] cap_score_ff;
   logic [7:0]  cap_type_ff;

   osbm_pkg::exp_entry_type exp_mem [NL];
   osbm_pkg::det_entry_type det_mem [ND];
   osbm_pkg::exp_entry_type exp_rdata_ff;
   osbm_pkg::det_entry_type det_rdata_ff;

   logic [LC-1:0] exp_count_ff;
   logic [DC-1:0] det_count_ff;
   logic [15:0]   last_id_ff;

   logic signed [PW-1:0] ecx_ff, ecy_ff, offx_ff, offy_ff, ex_ff, ey_ff;
   logic [15:0]          outer_id_ff, inner_id_ff;
   logic [11:0]          ew_ff, eh_ff;
   logic [QW-1:0]        top_ff;
   logic [DI-1:0]        choice_ff;
   logic                 ivalid_ff;
   logic [TW-1:0]        sum_ff, best_ff;

   // two choice banks: the one not selected collects the current evaluation
   logic [DI-1:0] bank_choice_ff [2][NL];
   logic          bank_valid_ff  [2][NL];
   logic          best_sel_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic        rsp_match_ff;
   logic [15:0] rsp_id_ff;
   logic [7:0]  rsp_type_ff;
   logic [11:0] rsp_x_ff, rsp_y_ff, rsp_w_ff, rsp_h_ff;
   logic        rsp_last_ff;

   logic          iou_done;
   logic [QW-1:0] iou_q;

   osbm_pkg::status_type exp_status, det_status;
   logic [12:0]          frame_w, frame_h;
   logic signed [14:0]   bx, by, lx, ly, rxr, ryr, rx, ry, wm1, wm2, hm1, hm2;
   logic [DI-1:0]        det_raddr;
   logic [TW:0]          sum_wide;
   logic                 later_valid;
   logic                 rsp_free;

   osbm_iou u_iou (
      .clock (clock),
      .reset (reset),
      .start (cmd.iou_start),
      .ex    (ex_ff),
      .ey    (ey_ff),
      .ew    (ew_ff),
      .eh    (eh_ff),
      .dx    (det_rdata_ff.x),
      .dy    (det_rdata_ff.y),
      .dw    (det_rdata_ff.w),
      .dh    (det_rdata_ff.h),
      .score (det_rdata_ff.score),
      .done  (iou_done),
      .q     (iou_q)
   );

   always_comb begin
      rsp_free = !rsp_valid_ff || rsp_ready;

      if (exp_count_ff >= LC'(NL)) begin
         exp_status = osbm_pkg::ST_FULL;
      end else if (exp_count_ff != '0 && cap_id_ff <= last_id_ff) begin
         exp_status = osbm_pkg::ST_ORDER;
      end else begin
         exp_status = osbm_pkg::ST_ACCEPTED;
      end

      if (cap_score_ff < threshold_ff) begin
         det_status = osbm_pkg::ST_DROPPED;
      end else if (det_count_ff >= DC'(ND)) begin
         det_status = osbm_pkg::ST_FULL;
      end else begin
         det_status = osbm_pkg::ST_ACCEPTED;
      end

      // saturate the frame size into [2, 4096]
      if (width_ff < 13'd2) frame_w = 13'd2;
      else if (width_ff > 13'd4096) frame_w = 13'd4096;
      else frame_w = width_ff;
      if (height_ff < 13'd2) frame_h = 13'd2;
      else if (height_ff > 13'd4096) frame_h = 13'd4096;
      else frame_h = height_ff;

      wm2 = $signed({2'b00, frame_w}) - 15'sd2;
      wm1 = $signed({2'b00, frame_w}) - 15'sd1;
      hm2 = $signed({2'b00, frame_h}) - 15'sd2;
      hm1 = $signed({2'b00, frame_h}) - 15'sd1;
      bx  = $signed({{2{cap_x_ff[12]}}, cap_x_ff});
      by  = $signed({{2{cap_y_ff[12]}}, cap_y_ff});

      if (bx < 0) lx = '0;
      else if (bx > wm2) lx = wm2;
      else lx = bx;
      if (by < 0) ly = '0;
      else if (by > hm2) ly = hm2;
      else ly = by;

      rxr = bx + $signed({3'b000, cap_w_ff});
      ryr = by + $signed({3'b000, cap_h_ff});
      if (rxr > wm1) rx = wm1;
      else if (rxr < lx + 15'sd1) rx = lx + 15'sd1;
      else rx = rxr;
      if (ryr > hm1) ry = hm1;
      else if (ryr < ly + 15'sd1) ry = ly + 15'sd1;
      else ry = ryr;

      det_raddr = cmd.det_use_choice ? bank_choice_ff[best_sel_ff][cmd.exp_addr]
                                     : cmd.det_addr;

      sum_wide = {1'b0, sum_ff} + {{(TW+1-QW){1'b0}}, top_ff};

      // any valid choice after the current index within the expected count
      later_valid = 1'b0;
      for (int k = 0; k < NL; k++) begin
         if (LI'(k) > cmd.exp_addr && LC'(k) < exp_count_ff &&
             bank_valid_ff[best_sel_ff][k]) begin
            later_valid = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= osbm_pkg::WIDTH_RESET;
         height_ff    <= osbm_pkg::HEIGHT_RESET;
         threshold_ff <= osbm_pkg::THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            osbm_pkg::CSR_IMAGE_WIDTH:     width_ff     <= csr_wdata[12:0];
            osbm_pkg::CSR_IMAGE_HEIGHT:    height_ff    <= csr_wdata[12:0];
            osbm_pkg::CSR_SCORE_THRESHOLD: threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_id_ff    <= req_light_id;
         cap_x_ff     <= req_box_x;
         cap_y_ff     <= req_box_y;
         cap_w_ff     <= req_box_w;
         cap_h_ff     <= req_box_h;
         cap_score_ff <= req_det_score;
         cap_type_ff  <= req_light_type;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.load_exp && rsp_free && exp_status == osbm_pkg::ST_ACCEPTED) begin
         exp_mem[exp_count_ff[LI-1:0]] <= '{id: cap_id_ff, x: cap_x_ff, y: cap_y_ff,
                                            w: cap_w_ff, h: cap_h_ff,
                                            light_type: cap_type_ff};
      end
      if (cmd.exp_rd) begin
         exp_rdata_ff <= exp_mem[cmd.exp_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_det && rsp_free && det_status == osbm_pkg::ST_ACCEPTED) begin
         det_mem[det_count_ff[DI-1:0]] <= '{id: cap_id_ff, x: lx[11:0], y: ly[11:0],
                                            w: 12'(rx - lx), h: 12'(ry - ly),
                                            score: cap_score_ff};
      end
      if (cmd.det_rd) begin
         det_rdata_ff <= det_mem[det_raddr];
      end
   end

   // counts, best total and bank select
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_count_ff <= '0;
         det_count_ff <= '0;
         best_ff      <= '0;
         best_sel_ff  <= 1'b0;
      end else begin
         if (cmd.load_exp && rsp_free && exp_status == osbm_pkg::ST_ACCEPTED) begin
            exp_count_ff <= exp_count_ff + 1'b1;
         end
         if (cmd.load_det && rsp_free && det_status == osbm_pkg::ST_ACCEPTED) begin
            det_count_ff <= det_count_ff + 1'b1;
         end
         if (cmd.run_init) begin
            best_ff <= '0;
         end
         if (cmd.eval_commit && sum_ff > best_ff) begin
            best_ff     <= sum_ff;
            best_sel_ff <= ~best_sel_ff;
         end
         // clear the stores once the final result item goes out
         if (rsp_free && (cmd.emit_none || (cmd.emit_match && !later_valid))) begin
            exp_count_ff <= '0;
            det_count_ff <= '0;
            best_ff      <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_exp && rsp_free && exp_status == osbm_pkg::ST_ACCEPTED) begin
         last_id_ff <= cap_id_ff;
      end
      if (cmd.latch_outer) begin
         outer_id_ff <= exp_rdata_ff.id;
         ecx_ff <= $signed({{(PW-13){exp_rdata_ff.x[12]}}, exp_rdata_ff.x}) +
                   $signed({{(PW-11){1'b0}}, exp_rdata_ff.w[11:1]});
         ecy_ff <= $signed({{(PW-13){exp_rdata_ff.y[12]}}, exp_rdata_ff.y}) +
                   $signed({{(PW-11){1'b0}}, exp_rdata_ff.h[11:1]});
      end
      if (cmd.latch_offset) begin
         offx_ff <= $signed({{(PW-12){1'b0}}, det_rdata_ff.x}) +
                    $signed({{(PW-11){1'b0}}, det_rdata_ff.w[11:1]}) - ecx_ff;
         offy_ff <= $signed({{(PW-12){1'b0}}, det_rdata_ff.y}) +
                    $signed({{(PW-11){1'b0}}, det_rdata_ff.h[11:1]}) - ecy_ff;
         sum_ff  <= '0;
      end
      if (cmd.latch_inner) begin
         inner_id_ff <= exp_rdata_ff.id;
         ex_ff <= $signed({{(PW-13){exp_rdata_ff.x[12]}}, exp_rdata_ff.x}) + offx_ff;
         ey_ff <= $signed({{(PW-13){exp_rdata_ff.y[12]}}, exp_rdata_ff.y}) + offy_ff;
         ew_ff <= exp_rdata_ff.w;
         eh_ff <= exp_rdata_ff.h;
         top_ff    <= '0;
         choice_ff <= '0;
         ivalid_ff <= 1'b0;
      end
      // equal score from a later detection takes over
      if (cmd.iou_take && iou_q >= top_ff) begin
         top_ff    <= iou_q;
         choice_ff <= cmd.det_addr;
         ivalid_ff <= 1'b1;
      end
      if (cmd.eval_store) begin
         bank_choice_ff[~best_sel_ff][cmd.exp_addr] <= choice_ff;
         bank_valid_ff[~best_sel_ff][cmd.exp_addr]  <= ivalid_ff;
         sum_ff <= sum_wide[TW] ? {TW{1'b1}} : sum_wide[TW-1:0];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= cmd.load_exp || cmd.load_det || cmd.emit_match || cmd.emit_none;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         if (cmd.load_exp || cmd.load_det) begin
            rsp_status_ff <= cmd.load_exp ? exp_status : det_status;
            rsp_match_ff  <= 1'b0;
            rsp_id_ff     <= '0;
            rsp_type_ff   <= '0;
            rsp_x_ff      <= '0;
            rsp_y_ff      <= '0;
            rsp_w_ff      <= '0;
            rsp_h_ff      <= '0;
            rsp_last_ff   <= 1'b0;
         end else if (cmd.emit_match) begin
            rsp_status_ff <= osbm_pkg::ST_ACCEPTED;
            rsp_match_ff  <= 1'b1;
            rsp_id_ff     <= exp_rdata_ff.id;
            rsp_type_ff   <= exp_rdata_ff.light_type;
            rsp_x_ff      <= det_rdata_ff.x;
            rsp_y_ff      <= det_rdata_ff.y;
            rsp_w_ff      <= det_rdata_ff.w;
            rsp_h_ff      <= det_rdata_ff.h;
            rsp_last_ff   <= !later_valid;
         end else if (cmd.emit_none) begin
            rsp_status_ff <= osbm_pkg::ST_ACCEPTED;
            rsp_match_ff  <= 1'b0;
            rsp_id_ff     <= '0;
            rsp_type_ff   <= '0;
            rsp_x_ff      <= '0;
            rsp_y_ff      <= '0;
            rsp_w_ff      <= '0;
            rsp_h_ff      <= '0;
            rsp_last_ff   <= 1'b1;
         end
      end
   end

   always_comb begin
      stat.exp_count   = exp_count_ff;
      stat.det_count   = det_count_ff;
      stat.outer_match = det_rdata_ff.id == outer_id_ff;
      stat.inner_match = det_rdata_ff.id == inner_id_ff;
      stat.iou_done    = iou_done;
      stat.best_zero   = best_ff == '0;
      stat.best_valid  = bank_valid_ff[best_sel_ff][cmd.exp_addr];
      stat.last_item   = !later_valid;
      stat.rsp_free    = rsp_free;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_match_found = rsp_match_ff;
   assign rsp_out_id      = rsp_id_ff;
   assign rsp_out_type    = rsp_type_ff;
   assign rsp_out_x       = rsp_x_ff;
   assign rsp_out_y       = rsp_y_ff;
   assign rsp_out_w       = rsp_w_ff;
   assign rsp_out_h       = rsp_h_ff;
   assign rsp_last        = rsp_last_ff;
endmodule

@@ rtl/osbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// osbm_ctrl: sequencer of the matcher
// Accepts requests, runs the load steps and walks the outer offset loop, the
// evaluation loops and the emission loop by issuing datapath commands.
// ----------------------------------------------------------------------------
module osbm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_command,
   output logic                     req_ready,
   output osbm_pkg::dp_cmd_type     cmd,
   input  osbm_pkg::dp_status_type  stat
);
   localparam int LI = osbm_pkg::LIGHT_IDX_W;
   localparam int LC = osbm_pkg::LIGHT_CNT_W;
   localparam int DI = osbm_pkg::DET_IDX_W;
   localparam int DC = osbm_pkg::DET_CNT_W;

   osbm_pkg::state_type state_ff, state_in;
   logic [LC-1:0] oi_ff, oi_in, ei_ff, ei_in;
   logic [DC-1:0] oj_ff, oj_in, ej_ff, ej_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= osbm_pkg::S_IDLE;
         oi_ff    <= '0;
         ei_ff    <= '0;
         oj_ff    <= '0;
         ej_ff    <= '0;
      end else begin
         state_ff <= state_in;
         oi_ff    <= oi_in;
         ei_ff    <= ei_in;
         oj_ff    <= oj_in;
         ej_ff    <= ej_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      oi_in     = oi_ff;
      ei_in     = ei_ff;
      oj_in     = oj_ff;
      ej_in     = ej_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.exp_addr = ei_ff[LI-1:0];
      cmd.det_addr = ej_ff[DI-1:0];

      unique case (state_ff)
         osbm_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (osbm_pkg::command_type'(req_command))
                  osbm_pkg::CMD_LOAD_EXPECTED:  state_in = osbm_pkg::S_LOAD_EXP;
                  osbm_pkg::CMD_LOAD_DETECTION: state_in = osbm_pkg::S_LOAD_DET;
                  osbm_pkg::CMD_RUN:            state_in = osbm_pkg::S_RUN_START;
                  default:                      state_in = osbm_pkg::S_IDLE;
               endcase
            end
         end
         osbm_pkg::S_LOAD_EXP: begin
            cmd.load_exp = 1'b1;
            if (stat.rsp_free) state_in = osbm_pkg::S_IDLE;
         end
         osbm_pkg::S_LOAD_DET: begin
            cmd.load_det = 1'b1;
            if (stat.rsp_free) state_in = osbm_pkg::S_IDLE;
         end
         osbm_pkg::S_RUN_START: begin
            cmd.run_init = 1'b1;
            oi_in    = '0;
            state_in = osbm_pkg::S_OUTER_CHK;
         end
         osbm_pkg::S_OUTER_CHK: begin
            cmd.exp_addr = oi_ff[LI-1:0];
            if (oi_ff < stat.exp_count) begin
               cmd.exp_rd = 1'b1;
               state_in   = osbm_pkg::S_OUTER_LATCH;
            end else begin
               state_in = osbm_pkg::S_EMIT_START;
            end
         end
         osbm_pkg::S_OUTER_LATCH: begin
            cmd.latch_outer = 1'b1;
            oj_in    = '0;
            state_in = osbm_pkg::S_PAIR_CHK;
         end
         osbm_pkg::S_PAIR_CHK: begin
            cmd.det_addr = oj_ff[DI-1:0];
            if (oj_ff < stat.det_count) begin
               cmd.det_rd = 1'b1;
               state_in   = osbm_pkg::S_PAIR_TEST;
            end else begin
               oi_in    = oi_ff + 1'b1;
               state_in = osbm_pkg::S_OUTER_CHK;
            end
         end
         osbm_pkg::S_PAIR_TEST: begin
            if (stat.outer_match) begin
               cmd.latch_offset = 1'b1;
               ei_in    = '0;
               state_in = osbm_pkg::S_EVAL_CHK;
            end else begin
               oj_in    = oj_ff + 1'b1;
               state_in = osbm_pkg::S_PAIR_CHK;
            end
         end
         osbm_pkg::S_EVAL_CHK: begin
            if (ei_ff < stat.exp_count) begin
               cmd.exp_rd = 1'b1;
               state_in   = osbm_pkg::S_EVAL_LATCH;
            end else begin
               state_in = osbm_pkg::S_EVAL_END;
            end
         end
         osbm_pkg::S_EVAL_LATCH: begin
            cmd.latch_inner = 1'b1;
            ej_in    = '0;
            state_in = osbm_pkg::S_SCAN_CHK;
         end
         osbm_pkg::S_SCAN_CHK: begin
            if (ej_ff < stat.det_count) begin
               cmd.det_rd = 1'b1;
               state_in   = osbm_pkg::S_SCAN_TEST;
            end else begin
               state_in = osbm_pkg::S_EVAL_STORE;
            end
         end
         osbm_pkg::S_SCAN_TEST: begin
            if (stat.inner_match) begin
               cmd.iou_start = 1'b1;
               state_in      = osbm_pkg::S_SCAN_WAIT;
            end else begin
               ej_in    = ej_ff + 1'b1;
               state_in = osbm_pkg::S_SCAN_CHK;
            end
         end
         osbm_pkg::S_SCAN_WAIT: begin
            if (stat.iou_done) begin
               cmd.iou_take = 1'b1;
               ej_in    = ej_ff + 1'b1;
               state_in = osbm_pkg::S_SCAN_CHK;
            end
         end
         osbm_pkg::S_EVAL_STORE: begin
            cmd.eval_store = 1'b1;
            ei_in    = ei_ff + 1'b1;
            state_in = osbm_pkg::S_EVAL_CHK;
         end
         osbm_pkg::S_EVAL_END: begin
            cmd.eval_commit = 1'b1;
            oj_in    = oj_ff + 1'b1;
            state_in = osbm_pkg::S_PAIR_CHK;
         end
         osbm_pkg::S_EMIT_START: begin
            ei_in = '0;
            if (stat.best_zero) state_in = osbm_pkg::S_EMIT_NONE;
            else state_in = osbm_pkg::S_EMIT_CHK;
         end
         osbm_pkg::S_EMIT_NONE: begin
            cmd.emit_none = 1'b1;
            if (stat.rsp_free) state_in = osbm_pkg::S_IDLE;
         end
         osbm_pkg::S_EMIT_CHK: begin
            // a nonzero best total guarantees a valid entry further on
            if (stat.best_valid) begin
               cmd.exp_rd         = 1'b1;
               cmd.det_rd         = 1'b1;
               cmd.det_use_choice = 1'b1;
               state_in           = osbm_pkg::S_EMIT_OUT;
            end else begin
               ei_in = ei_ff + 1'b1;
            end
         end
         osbm_pkg::S_EMIT_OUT: begin
            cmd.emit_match = 1'b1;
            if (stat.rsp_free) begin
               if (stat.last_item) begin
                  state_in = osbm_pkg::S_IDLE;
               end else begin
                  ei_in    = ei_ff + 1'b1;
                  state_in = osbm_pkg::S_EMIT_CHK;
               end
            end
         end
         default: state_in = osbm_pkg::S_IDLE;
      endcase
   end
endmodule

@@ rtl/offset_search_box_matcher.sv @@
// ----------------------------------------------------------------------------
// offset_search_box_matcher: offset search matcher of expected and found boxes
// Loads expected boxes and detections, then searches the best center offset.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command per transaction: load expected box, load
//   detection, or run. Each load returns one rsp_chan transaction with its
//   status, set in the response register once the load state finds it free.
//   A run returns one transaction per matched id in ascending order,
//   or a single no-match transaction, the final one flagged by last; both
//   stores are then empty.
//   The block takes one request at a time; a request is accepted only while
//   the sequencer is idle, which it is again once the previous result is in
//   the response register, so a held result does not block the next accept.
//   Before the first result of a run, every id-matching pair of an expected
//   box and a detection sets one offset, and each offset runs the single
//   shared IoU unit (4 steps plus a divider) once per id-matching pair.
//   Further results follow as the emission loop steps over skipped ids.
//   If rsp_chan.ready stays low, the sequencer holds at the next result.
//   Reset is synchronous: counts go to zero, frame registers to 1920 x 1080,
//   threshold to 0.3; stores need no clearing. csr_* writes take effect at
//   once and must be made while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module offset_search_box_matcher (
   input  logic                                 clock,
   input  logic                                 reset,
   osbm_req_if.sink                             req_chan,
   osbm_rsp_if.source                           rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [osbm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [osbm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   osbm_pkg::dp_cmd_type    cmd;
   osbm_pkg::dp_status_type stat;
   logic                    req_ready;

   osbm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_ready),
      .cmd         (cmd),
      .stat        (stat)
   );

   osbm_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_light_id    (req_chan.light_id),
      .req_box_x       (req_chan.box_x),
      .req_box_y       (req_chan.box_y),
      .req_box_w       (req_chan.box_w),
      .req_box_h       (req_chan.box_h),
      .req_det_score   (req_chan.det_score),
      .req_light_type  (req_chan.light_type),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_status      (rsp_chan.status),
      .rsp_match_found (rsp_chan.match_found),
      .rsp_out_id      (rsp_chan.out_id),
      .rsp_out_type    (rsp_chan.out_type),
      .rsp_out_x       (rsp_chan.out_x),
      .rsp_out_y       (rsp_chan.out_y),
      .rsp_out_w       (rsp_chan.out_w),
      .rsp_out_h       (rsp_chan.out_h),
      .rsp_last        (rsp_chan.last)
   );

   assign req_chan.ready = req_ready;
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench of the offset search box matcher
// Drives a directed table and then random load and run sequences through the
// request channel. A scoreboard predicts each result, including the full offset
// search of a run, and compares it field by field with the response channel.
// Idling on both sides and CSR changes between phases.
// ----------------------------------------------------------------------------
module tb;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int NL = osbm_pkg::MAX_LIGHTS;
   localparam int ND = osbm_pkg::MAX_DETECTIONS;

   typedef struct packed {
      osbm_pkg::command_type cmd;
      logic [15:0] id;
      logic [12:0] x;
      logic [12:0] y;
      logic [11:0] w;
      logic [11:0] h;
      logic [15:0] score;
      logic [7:0]  ltype;
   } match_req_type;

   typedef struct packed {
      osbm_pkg::status_type status;
      logic        found;
      logic [15:0] id;
      logic [7:0]  ltype;
      logic [11:0] x;
      logic [11:0] y;
      logic [11:0] w;
      logic [11:0] h;
      logic        last;
   } match_rsp_type;

   typedef struct {
      bit                      is_csr;
      osbm_pkg::csr_index_type csr_sel;
      logic [15:0]             csr_val;
      match_req_type           item;
      bit                      typed;
      match_rsp_type           want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   osbm_pkg::csr_index_type csr_index;
   logic [15:0] csr_wdata;

   osbm_req_if req_if ();
   osbm_rsp_if rsp_if ();

   offset_search_box_matcher i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block
   logic [12:0] frame_w_reg, frame_h_reg;
   logic [15:0] thr_reg;
   logic [15:0] exp_id[NL];
   int          exp_x[NL], exp_y[NL], exp_w[NL], exp_h[NL];
   logic [7:0]  exp_type[NL];
   int          exp_n;
   logic [15:0] det_id[ND];
   int          det_x[ND], det_y[ND];
   int          det_w[ND], det_h[ND];
   int unsigned det_s[ND];
   int          det_n;
   int          trial_pick[NL];
   bit          trial_ok[NL];
   int          win_pick[NL];
   bit          win_ok[NL];

   match_rsp_type pending_rsp_q[$];
   match_rsp_type predicted_q[$];
   stim_row_type  directed_rows[$];

   int mismatches = 0;
   int idle_cycles;
   int send_idle, recv_idle;
   bit det_fill_done;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int frame_dim(logic [12:0] r);
      if (r < 2) return 2;
      if (r > 4096) return 4096;
      return int'(r);
   endfunction

   function automatic int clip(int v, int lo, int hi);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   function automatic int unsigned scored_overlap(longint ex, longint ey, longint ew,
                                                  longint eh, int d);
      longint dx, dy, dw, dh, x1, x2, y1, y2, iw, ih, inter, uni;
      dx = det_x[d]; dy = det_y[d]; dw = det_w[d]; dh = det_h[d];
      x1 = ex > dx ? ex : dx;
      x2 = (ex + ew) < (dx + dw) ? (ex + ew) : (dx + dw);
      y1 = ey > dy ? ey : dy;
      y2 = (ey + eh) < (dy + dh) ? (ey + eh) : (dy + dh);
      iw = x2 - x1 > 0 ? x2 - x1 : 0;
      ih = y2 - y1 > 0 ? y2 - y1 : 0;
      inter = iw * ih;
      uni = ew * eh + dw * dh - inter;
      if (uni <= 0) return 0;
      return int'((longint'(det_s[d]) * inter) / uni);
   endfunction

   // total of best overlaps with all expected boxes shifted by one offset
   function automatic int unsigned offset_total(longint offx, longint offy);
      int unsigned sum, top, s;
      sum = 0;
      for (int i = 0; i < exp_n; i++) begin
         top = 0;
         trial_ok[i] = 1'b0;
         trial_pick[i] = 0;
         for (int j = 0; j < det_n; j++) begin
            if (det_id[j] != exp_id[i]) continue;
            s = scored_overlap(longint'(exp_x[i]) + offx, longint'(exp_y[i]) + offy,
                               exp_w[i], exp_h[i], j);
            if (s >= top) begin
               top = s;
               trial_pick[i] = j;
               trial_ok[i] = 1'b1;
            end
         end
         sum += top;
         if (sum > 20'hFFFFF) sum = 20'hFFFFF;
      end
      return sum;
   endfunction

   // advance the shadow by one accepted transaction; results go to predicted_q
   function automatic void predict_match(match_req_type r);
      match_rsp_type o;
      int wd, ht, lx, ly, rx, ry, bx, by, d;
      int unsigned best, s;
      longint ecx, ecy;
      o = '0;
      bx = int'($signed(r.x));
      by = int'($signed(r.y));
      case (r.cmd)
         osbm_pkg::CMD_LOAD_EXPECTED: begin
            if (exp_n >= NL) o.status = osbm_pkg::ST_FULL;
            else if (exp_n > 0 && r.id <= exp_id[exp_n-1]) o.status = osbm_pkg::ST_ORDER;
            else begin
               exp_id[exp_n] = r.id; exp_x[exp_n] = bx; exp_y[exp_n] = by;
               exp_w[exp_n] = int'(r.w); exp_h[exp_n] = int'(r.h);
               exp_type[exp_n] = r.ltype;
               exp_n++;
            end
            predicted_q.insert(predicted_q.size(), o);
         end
         osbm_pkg::CMD_LOAD_DETECTION: begin
            if (r.score < thr_reg) o.status = osbm_pkg::ST_DROPPED;
            else if (det_n >= ND) o.status = osbm_pkg::ST_FULL;
            else begin
               wd = frame_dim(frame_w_reg);
               ht = frame_dim(frame_h_reg);
               lx = clip(bx, 0, wd - 2);
               ly = clip(by, 0, ht - 2);
               rx = clip(bx + int'(r.w), lx + 1, wd - 1);
               ry = clip(by + int'(r.h), ly + 1, ht - 1);
               det_id[det_n] = r.id; det_x[det_n] = lx; det_y[det_n] = ly;
               det_w[det_n] = rx - lx; det_h[det_n] = ry - ly;
               det_s[det_n] = r.score;
               det_n++;
            end
            predicted_q.insert(predicted_q.size(), o);
         end
         osbm_pkg::CMD_RUN: begin
            best = 0;
            for (int i = 0; i < NL; i++) win_ok[i] = 1'b0;
            for (int i = 0; i < exp_n; i++) begin
               ecx = longint'(exp_x[i]) + (exp_w[i] >> 1);
               ecy = longint'(exp_y[i]) + (exp_h[i] >> 1);
               for (int j = 0; j < det_n; j++) begin
                  if (det_id[j] != exp_id[i]) continue;
                  s = offset_total(longint'(det_x[j]) + det_w[j] / 2 - ecx,
                                   longint'(det_y[j]) + det_h[j] / 2 - ecy);
                  if (s > best) begin
                     best = s;
                     win_pick = trial_pick;
                     win_ok = trial_ok;
                  end
               end
            end
            for (int i = 0; i < exp_n; i++) begin
               if (!win_ok[i]) continue;
               d = win_pick[i];
               o = '0;
               o.found = 1'b1;
               o.id = exp_id[i];
               o.ltype = exp_type[i];
               o.x = det_x[d][11:0]; o.y = det_y[d][11:0];
               o.w = det_w[d][11:0]; o.h = det_h[d][11:0];
               predicted_q.insert(predicted_q.size(), o);
            end
            if (predicted_q.size() == 0) begin
               o = '0;
               predicted_q.insert(0, o);
            end
            predicted_q[predicted_q.size()-1].last = 1'b1;
            exp_n = 0;
            det_n = 0;
         end
         default: ;
      endcase
   endfunction

   task automatic send_match(match_req_type r, bit typed, match_rsp_type want);
      while ($urandom_range(0, 99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.command    <= r.cmd;
      req_if.light_id   <= r.id;
      req_if.box_x      <= r.x;
      req_if.box_y      <= r.y;
      req_if.box_w      <= r.w;
      req_if.box_h      <= r.h;
      req_if.det_score  <= r.score;
      req_if.light_type <= r.ltype;
      do @(posedge clock); while (!req_if.ready);
      predicted_q.delete();
      predict_match(r);
      if (typed) pending_rsp_q.insert(pending_rsp_q.size(), want);
      else foreach (predicted_q[k]) pending_rsp_q.insert(pending_rsp_q.size(), predicted_q[k]);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(osbm_pkg::csr_index_type sel, logic [15:0] val);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (sel)
         osbm_pkg::CSR_IMAGE_WIDTH:  frame_w_reg = val[12:0];
         osbm_pkg::CSR_IMAGE_HEIGHT: frame_h_reg = val[12:0];
         default:                    thr_reg = val;
      endcase
   endtask

   function automatic match_req_type make_req(osbm_pkg::command_type c, int id, int x, int y,
                                              int w, int h, int score, int ltype);
      match_req_type r;
      r.cmd = c; r.id = id[15:0]; r.x = x[12:0]; r.y = y[12:0];
      r.w = w[11:0]; r.h = h[11:0]; r.score = score[15:0]; r.ltype = ltype[7:0];
      return r;
   endfunction

   function automatic void add_row(match_req_type r, bit typed = 0,
                                   osbm_pkg::status_type st = osbm_pkg::ST_ACCEPTED,
                                   bit last = 0);
      stim_row_type row;
      row.is_csr = 1'b0;
      row.csr_sel = osbm_pkg::CSR_IMAGE_WIDTH;
      row.csr_val = '0;
      row.item = r;
      row.typed = typed;
      row.want = '0;
      row.want.status = st;
      row.want.last = last;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic void add_csr(osbm_pkg::csr_index_type sel, int val);
      stim_row_type row;
      row.is_csr = 1'b1;
      row.csr_sel = sel;
      row.csr_val = val[15:0];
      row.item = '0;
      row.typed = 1'b0;
      row.want = '0;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic match_req_type noise_req();
      match_req_type r;
      r.cmd = osbm_pkg::command_type'($urandom_range(0, 3));
      r.id = 16'($urandom); r.x = 13'($urandom); r.y = 13'($urandom);
      r.w = 12'($urandom); r.h = 12'($urandom);
      r.score = 16'($urandom); r.ltype = 8'($urandom);
      return r;
   endfunction

   // load sequences ending in a run, with some noise and broken orders
   task automatic random_phase(int budget);
      int sent, ne, base, step, ox, oy, jx, jy, sc, ex, ey, ew, eh;
      int bxs[4], bys[4], bws[4], bhs[4], ids[4];
      sent = 0;
      while (sent < budget) begin
         case ($urandom_range(0, 19))
            0: begin
               base = $urandom_range(0, 100);
               for (int k = 0; k < NL + 1; k++)
                  send_match(make_req(osbm_pkg::CMD_LOAD_EXPECTED,
                             base + k * $urandom_range(1, 9),
                             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom),
                             0, '0);
               send_match(make_req(osbm_pkg::CMD_RUN, 0, 0, 0, 0, 0, 0, 0), 0, '0);
               sent += NL + 2;
            end
            1: begin
               if (!det_fill_done) begin
                  det_fill_done = 1;
                  send_match(make_req(osbm_pkg::CMD_RUN, 0, 0, 0, 0, 0, 0, 0), 0, '0);
                  for (int k = 0; k < ND + 1; k++)
                     send_match(make_req(osbm_pkg::CMD_LOAD_DETECTION, $urandom, $urandom,
                                $urandom, $urandom, $urandom,
                                $urandom_range(thr_reg, 65535), $urandom), 0, '0);
                  send_match(make_req(osbm_pkg::CMD_RUN, 0, 0, 0, 0, 0, 0, 0), 0, '0);
                  sent += ND + 3;
               end
            end
            2, 3: begin
               send_match(noise_req(), 0, '0);
               sent++;
            end
            default: begin
               ne = $urandom_range(1, 4);
               base = $urandom_range(0, 65000);
               step = $urandom_range(1, 100);
               ox = $urandom_range(0, 60) - 30;
               oy = $urandom_range(0, 60) - 30;
               for (int k = 0; k < ne; k++) begin
                  ids[k] = base + k * step;
                  bxs[k] = $urandom_range(0, 600); bys[k] = $urandom_range(0, 400);
                  bws[k] = $urandom_range(1, 120); bhs[k] = $urandom_range(1, 120);
                  send_match(make_req(osbm_pkg::CMD_LOAD_EXPECTED, ids[k], bxs[k], bys[k],
                             bws[k], bhs[k], $urandom, $urandom), 0, '0);
                  sent++;
               end
               if ($urandom_range(0, 4) == 0) begin
                  send_match(make_req(osbm_pkg::CMD_LOAD_EXPECTED, ids[0], $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom), 0, '0);
                  sent++;
               end
               for (int k = 0; k < ne; k++) begin
                  for (int m = $urandom_range(1, 2); m > 0; m--) begin
                     jx = $urandom_range(0, 6) - 3; jy = $urandom_range(0, 6) - 3;
                     ex = bxs[k] + ox + jx; ey = bys[k] + oy + jy;
                     ew = bws[k] + $urandom_range(0, 8); eh = bhs[k] + $urandom_range(0, 8);
                     sc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(thr_reg, 65535);
                     send_match(make_req(osbm_pkg::CMD_LOAD_DETECTION,
                                ($urandom_range(0, 9) == 0) ? $urandom : ids[k],
                                ex, ey, ew, eh, sc, $urandom), 0, '0);
                     sent++;
                  end
               end
               send_match(make_req(osbm_pkg::CMD_RUN, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom), 0, '0);
               sent++;
            end
         endcase
      end
   endtask

   // response side: random back-pressure, checking and watchdog
   always @(posedge clock) begin
      match_rsp_type got, want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.status = osbm_pkg::status_type'(rsp_if.status);
            got.found = rsp_if.match_found;
            got.id = rsp_if.out_id;
            got.ltype = rsp_if.out_type;
            got.x = rsp_if.out_x; got.y = rsp_if.out_y;
            got.w = rsp_if.out_w; got.h = rsp_if.out_h;
            got.last = rsp_if.last;
            if (pending_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result: %p", got);
            end else begin
               want = pending_rsp_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle);
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
            idle_cycles <= 0;
         else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end else idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = osbm_pkg::CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.command = osbm_pkg::CMD_LOAD_EXPECTED;
      req_if.light_id = '0; req_if.box_x = '0; req_if.box_y = '0;
      req_if.box_w = '0; req_if.box_h = '0; req_if.det_score = '0; req_if.light_type = '0;
      det_fill_done = 0;
      send_idle = 19;
      recv_idle = 78;
      frame_w_reg = osbm_pkg::WIDTH_RESET;
      frame_h_reg = osbm_pkg::HEIGHT_RESET;
      thr_reg = osbm_pkg::THRESHOLD_RESET;
      exp_n = 0;
      det_n = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(make_req(osbm_pkg::CMD_RUN, 0, 0, 0, 0, 0, 0, 0), 1, osbm_pkg::ST_ACCEPTED, 1);
      add_row(make_req(osbm_pkg::CMD_LOAD_EXPECTED, 5, 100, 100, 40, 40, 0, 7), 1,
              osbm_pkg::ST_ACCEPTED);
      add_row(make_req(osbm_pkg::CMD_LOAD_EXPECTED, 5, 0, 0, 1, 1, 0, 1), 1,
              osbm_pkg::ST_ORDER);
      add_row(make_req(osbm_pkg::CMD_LOAD_EXPECTED, 4, 0, 0, 1, 1, 0, 1), 1,
              osbm_pkg::ST_ORDER);
      add_row(make_req(osbm_pkg::CMD_LOAD_DETECTION, 5, 0, 0, 1, 1, 0, 0), 1,
              osbm_pkg::ST_DROPPED);
      add_row(make_req(osbm_pkg::CMD_LOAD_DETECTION, 5, 110, 95, 40, 42, 65535, 0));
      add_row(make_req(osbm_pkg::CMD_LOAD_DETECTION, 5, -4096, -4096, 4095, 4095, 19661, 0));
      add_row(make_req(osbm_pkg::CMD_LOAD_DETECTION, 5, 4095, 4095, 0, 0, 19661, 0));
      add_row(make_req(osbm_pkg::CMD_UNUSED, 65535, -1, -1, 4095, 4095, 65535, 255));
      add_row(make_req(osbm_pkg::CMD_RUN, 0, 0, 0, 0, 0, 0, 0));
      add_csr(osbm_pkg::CSR_IMAGE_WIDTH, 8191);
      add_csr(osbm_pkg::CSR_IMAGE_HEIGHT, 0);
      add_csr(osbm_pkg::CSR_SCORE_THRESHOLD, 0);
      add_row(make_req(osbm_pkg::CMD_LOAD_EXPECTED, 0, 0, 0, 0, 0, 0, 255), 1,
              osbm_pkg::ST_ACCEPTED);
      add_row(make_req(osbm_pkg::CMD_LOAD_EXPECTED, 65535, 4095, -4096, 4095, 4095, 0, 0));
      add_row(make_req(osbm_pkg::CMD_LOAD_DETECTION, 0, 0, 0, 0, 0, 0, 0));
      add_row(make_req(osbm_pkg::CMD_LOAD_DETECTION, 65535, 4000, 0, 4095, 4095, 65535, 0));
      add_row(make_req(osbm_pkg::CMD_RUN, 0, 0, 0, 0, 0, 0, 0));
      add_csr(osbm_pkg::CSR_IMAGE_WIDTH, 1);
      add_csr(osbm_pkg::CSR_IMAGE_HEIGHT, 4096);
      add_csr(osbm_pkg::CSR_SCORE_THRESHOLD, 65535);
      add_row(make_req(osbm_pkg::CMD_LOAD_DETECTION, 9, 3, 3, 9, 9, 65534, 0), 1,
              osbm_pkg::ST_DROPPED);
      add_row(make_req(osbm_pkg::CMD_LOAD_EXPECTED, 9, 0, 0, 2, 2, 0, 3));
      add_row(make_req(osbm_pkg::CMD_LOAD_DETECTION, 9, 3, 3, 9, 9, 65535, 0));
      add_row(make_req(osbm_pkg::CMD_RUN, 0, 0, 0, 0, 0, 0, 0));

      foreach (directed_rows[n]) begin
         if (directed_rows[n].is_csr)
            write_csr(directed_rows[n].csr_sel, directed_rows[n].csr_val);
         else
            send_match(directed_rows[n].item, directed_rows[n].typed, directed_rows[n].want);
      end

      write_csr(osbm_pkg::CSR_IMAGE_WIDTH, 8191);
      write_csr(osbm_pkg::CSR_IMAGE_HEIGHT, 640);
      write_csr(osbm_pkg::CSR_SCORE_THRESHOLD, 0);
      random_phase(100);

      drain_results();
      send_idle = 78;
      recv_idle = 19;
      write_csr(osbm_pkg::CSR_IMAGE_WIDTH, 640);
      write_csr(osbm_pkg::CSR_IMAGE_HEIGHT, 480);
      write_csr(osbm_pkg::CSR_SCORE_THRESHOLD, 30000);
      random_phase(100);

      drain_results();
      send_idle = 0;
      recv_idle = 0;
      write_csr(osbm_pkg::CSR_IMAGE_WIDTH, 4096);
      write_csr(osbm_pkg::CSR_IMAGE_HEIGHT, 2);
      write_csr(osbm_pkg::CSR_SCORE_THRESHOLD, osbm_pkg::THRESHOLD_RESET);
      write_csr(osbm_pkg::CSR_IMAGE_HEIGHT, 4096);
      random_phase(100);

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_rsp_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
